// ===== hdl/kdt_pkg.sv =====
package kdt_pkg;

    localparam int KEY_W   = 8;
    localparam int COUNT_W = 8;
    localparam int LED_W   = 8;
    localparam int INDEX_W = 4;
    localparam int MODE_W  = 2;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    typedef logic [MODE_W-1:0] t_mode;

    localparam t_mode MODE_POLL     = 2'd0;
    localparam t_mode MODE_SEED     = 2'd1;
    localparam t_mode MODE_SET_ONE  = 2'd2;
    localparam t_mode MODE_SET_MASK = 2'd3;

    localparam logic REG_DEBOUNCE = 1'b0;
    localparam logic REG_POLARITY = 1'b1;

    localparam logic [COUNT_W-1:0] DEBOUNCE_RESET = 8'd3;
    localparam logic [COUNT_W-1:0] MIN_THRESHOLD  = 8'd2;
    localparam logic               POLARITY_RESET = 1'b1;

    typedef struct packed {
        t_mode              mode;
        logic [KEY_W-1:0]   sample;
        logic [INDEX_W-1:0] key_index;
        logic               led_on;
        logic [LED_W-1:0]   new_mask;
    } t_req;

    typedef struct packed {
        logic [LED_W-1:0] led_port;
        logic [LED_W-1:0] led_latch;
        logic [KEY_W-1:0] pressed_mask;
        logic [KEY_W-1:0] toggled_mask;
        logic             led_bit;
        logic             port_write;
        logic             error;
    } t_result;

endpackage

// ===== hdl/kdt_if.sv =====
interface kdt_req_if import kdt_pkg::*; ();
    logic               valid;
    logic               ready;
    t_mode              mode;
    logic [KEY_W-1:0]   sample;
    logic [INDEX_W-1:0] key_index;
    logic               led_on;
    logic [LED_W-1:0]   new_mask;

    modport source (output valid, mode, sample, key_index, led_on, new_mask, input ready);
    modport sink   (input valid, mode, sample, key_index, led_on, new_mask, output ready);
endinterface

interface kdt_rsp_if import kdt_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [LED_W-1:0] led_port;
    logic [LED_W-1:0] led_latch;
    logic [KEY_W-1:0] pressed_mask;
    logic [KEY_W-1:0] toggled_mask;
    logic             led_bit;
    logic             port_write;
    logic             error;

    modport source (output valid, led_port, led_latch, pressed_mask, toggled_mask,
                    led_bit, port_write, error, input ready);
    modport sink   (input valid, led_port, led_latch, pressed_mask, toggled_mask,
                    led_bit, port_write, error, output ready);
endinterface

// ===== hdl/keypad_debounce_toggle_latch.sv =====
// A result beat is registered in the output register, or in the skid slot behind it while the output is stalled.
// Throughput: one input beat per cycle while the skid slot is free, set by the update of the per-key lanes and
// the LED latch; a two-deep output register keeps accepting while one result waits.
// Reset: synchronous, active low; clears all debounce state, the LED latch and the valid flags of the output
// register and skid slot, and returns debounce_samples to 3 and led_active_high to 1. No clearing pass.
module keypad_debounce_toggle_latch import kdt_pkg::*; #(
    parameter int KEY_COUNT = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    kdt_req_if.sink           i_req,
    kdt_rsp_if.source         o_rsp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    // Configuration registers. Register i sits at byte address 4*i, so bit 2 of the
    // address selects between the two.
    logic [COUNT_W-1:0] r_debounce_samples;
    logic               r_led_active_high;
    logic               w_cfg_write;
    logic [COUNT_W-1:0] w_threshold;

    assign pready      = 1'b1;
    assign w_cfg_write = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_samples <= DEBOUNCE_RESET;
            r_led_active_high  <= POLARITY_RESET;
        end else if (w_cfg_write) begin
            case (paddr[2])
                REG_DEBOUNCE: r_debounce_samples <= pwdata[COUNT_W-1:0];
                REG_POLARITY: r_led_active_high  <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_DEBOUNCE: prdata = {{(APB_DW-COUNT_W){1'b0}}, r_debounce_samples};
            REG_POLARITY: prdata = {{(APB_DW-1){1'b0}}, r_led_active_high};
            default:      prdata = '0;
        endcase
    end

    // A threshold of zero or one behaves as two.
    assign w_threshold = (r_debounce_samples < MIN_THRESHOLD) ? MIN_THRESHOLD
                                                              : r_debounce_samples;

    // Input beat handshake. The block takes a beat whenever the skid slot is free.
    t_req  w_req;
    logic  r_skid_valid;
    logic  w_accept;

    assign i_req.ready = ~r_skid_valid;
    assign w_accept    = i_req.valid & ~r_skid_valid;

    always_comb begin
        w_req.mode      = i_req.mode;
        w_req.sample    = i_req.sample;
        w_req.key_index = i_req.key_index;
        w_req.led_on    = i_req.led_on;
        w_req.new_mask  = i_req.new_mask;
    end

    // One debounce lane per key. Keys at or above KEY_COUNT have no lane and read as
    // released, never toggling.
    logic [KEY_W-1:0] w_pressed;
    logic [KEY_W-1:0] w_toggled;

    for (genvar g = 0; g < KEY_W; g++) begin : g_lane
        if (g < KEY_COUNT) begin : g_key
            kdt_lane u_lane (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_accept    (w_accept),
                .i_mode      (w_req.mode),
                .i_level     (w_req.sample[g]),
                .i_threshold (w_threshold),
                .o_pressed   (w_pressed[g]),
                .o_toggle    (w_toggled[g])
            );
        end else begin : g_none
            assign w_pressed[g] = 1'b0;
            assign w_toggled[g] = 1'b0;
        end
    end

    // The merge stage updates the LED latch by mode (poll toggles, set-one, set-mask) and builds the result.
    logic [LED_W-1:0] r_latch;
    logic [LED_W-1:0] n_latch;
    t_result          w_result;

    kdt_merge #(
        .KEY_COUNT (KEY_COUNT)
    ) u_merge (
        .i_req         (w_req),
        .i_latch       (r_latch),
        .i_pressed     (w_pressed),
        .i_toggled     (w_toggled),
        .i_active_high (r_led_active_high),
        .o_latch       (n_latch),
        .o_result      (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_latch <= '0;
        end else if (w_accept) begin
            r_latch <= n_latch;
        end
    end

    // Output register with a skid slot behind it. A new beat only enters the skid
    // slot when the output register is full and not being drained this cycle.
    logic    r_out_valid;
    t_result r_out;
    t_result r_skid;
    logic    w_out_free;

    assign w_out_free = ~r_out_valid | o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= w_accept;
            end
        end else if (w_accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (w_accept) begin
                r_out <= w_result;
            end
        end else if (w_accept) begin
            r_skid <= w_result;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.led_port     = r_out.led_port;
    assign o_rsp.led_latch    = r_out.led_latch;
    assign o_rsp.pressed_mask = r_out.pressed_mask;
    assign o_rsp.toggled_mask = r_out.toggled_mask;
    assign o_rsp.led_bit      = r_out.led_bit;
    assign o_rsp.port_write   = r_out.port_write;
    assign o_rsp.error        = r_out.error;

    // The skid slot only fills behind a full output register.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid slot holds a beat while the output register is empty");

    // A set-mask beat loads the latch with its mask.
    a_set_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_req.mode == MODE_SET_MASK) |=> (r_latch == $past(w_req.new_mask)))
        else $error("set-mask beat did not load the LED latch");

    // An error result never asks for a port write.
    a_err_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.error) |-> !o_rsp.port_write)
        else $error("error result also requests a port write");

    // A seed beat leaves the latch untouched.
    a_seed_latch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_req.mode == MODE_SEED) |=> $stable(r_latch))
        else $error("seed beat changed the LED latch");

    // Nothing is shown on the output right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_rsp.valid)
        else $error("output valid right after reset");

endmodule

// ===== hdl/kdt_lane.sv =====
module kdt_lane import kdt_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  t_mode              i_mode,
    input  logic               i_level,
    input  logic [COUNT_W-1:0] i_threshold,
    output logic               o_pressed,
    output logic               o_toggle
);

    logic               r_candidate;
    logic [COUNT_W-1:0] r_count;
    logic               r_pressed;
    logic               n_candidate;
    logic [COUNT_W-1:0] n_count;
    logic               n_pressed;
    logic               n_toggle;
    logic [COUNT_W-1:0] w_inc;

    // The count only advances while it is below the threshold, so the increment cannot wrap.
    assign w_inc = r_count + COUNT_W'(1);

    always_comb begin
        n_candidate = r_candidate;
        n_count     = r_count;
        n_pressed   = r_pressed;
        n_toggle    = 1'b0;
        case (i_mode)
            MODE_POLL: begin
                if (i_level != r_candidate) begin
                    n_candidate = i_level;
                    n_count     = COUNT_W'(1);
                end else if (r_count < i_threshold) begin
                    n_count = w_inc;
                    if (w_inc == i_threshold) begin
                        n_pressed = i_level;
                        n_toggle  = i_level & ~r_pressed;
                    end
                end
            end
            MODE_SEED: begin
                n_candidate = i_level;
                n_count     = i_threshold;
                n_pressed   = i_level;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_candidate <= 1'b0;
            r_count     <= '0;
            r_pressed   <= 1'b0;
        end else if (i_accept) begin
            r_candidate <= n_candidate;
            r_count     <= n_count;
            r_pressed   <= n_pressed;
        end
    end

    assign o_pressed = n_pressed;
    assign o_toggle  = n_toggle;

endmodule

// ===== hdl/kdt_merge.sv =====
module kdt_merge import kdt_pkg::*; #(
    parameter int KEY_COUNT = 8
) (
    input  t_req             i_req,
    input  logic [LED_W-1:0] i_latch,
    input  logic [KEY_W-1:0] i_pressed,
    input  logic [KEY_W-1:0] i_toggled,
    input  logic             i_active_high,
    output logic [LED_W-1:0] o_latch,
    output t_result          o_result
);

    localparam logic [INDEX_W:0] KeyLimit = (INDEX_W+1)'(KEY_COUNT);

    logic             w_key_ok;
    logic [LED_W-1:0] n_latch;
    logic             w_pw;
    logic             w_err;
    logic [KEY_W-1:0] w_toggled;

    assign w_key_ok = {1'b0, i_req.key_index} < KeyLimit;

    always_comb begin
        n_latch   = i_latch;
        w_pw      = 1'b0;
        w_err     = 1'b0;
        w_toggled = '0;
        case (i_req.mode)
            MODE_POLL: begin
                w_toggled = i_toggled;
                n_latch   = i_latch ^ i_toggled;
                w_pw      = |i_toggled;
            end
            MODE_SEED: begin
            end
            MODE_SET_ONE: begin
                if (w_key_ok) begin
                    n_latch[i_req.key_index[2:0]] = i_req.led_on;
                    w_pw = 1'b1;
                end else begin
                    w_err = 1'b1;
                end
            end
            MODE_SET_MASK: begin
                n_latch = i_req.new_mask;
                w_pw    = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign o_latch = n_latch;

    always_comb begin
        o_result.led_port     = i_active_high ? n_latch : ~n_latch;
        o_result.led_latch    = n_latch;
        o_result.pressed_mask = i_pressed;
        o_result.toggled_mask = w_toggled;
        o_result.led_bit      = w_key_ok ? n_latch[i_req.key_index[2:0]] : 1'b0;
        o_result.port_write   = w_pw;
        o_result.error        = w_err;
    end

endmodule
